// ===== rtl/set_pkg.sv =====
// ----------------------------------------------------------------------------
// set_pkg
// Shared types and constants for the eased two-axis servo trajectory block.
// ----------------------------------------------------------------------------
package set_pkg;

    // step count limit (default of the top-level parameter)
    localparam int MAX_STEPS_DEF = 64;

    // field widths
    localparam int GOAL_W  = 8;
    localparam int DUR_W   = 11;
    localparam int ANGLE_W = 16;
    localparam int DUTY_W  = 14;
    localparam int CFG_W   = 13;
    localparam int IDX_W   = 2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_DUTY_OFFSET = 2'd0;
    localparam logic [IDX_W-1:0] REG_DUTY_SPAN   = 2'd1;

    // arithmetic constants
    localparam logic [ANGLE_W-1:0] RESET_POS_Q8  = 16'd23040;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX_Q8  = 16'd46080;
    localparam logic [CFG_W-1:0]   OFFSET_RESET  = 13'd205;
    localparam logic [CFG_W-1:0]   SPAN_RESET    = 13'd410;
    localparam logic [17:0]        BACK_S_Q16    = 18'd111515;
    localparam logic [17:0]        BACK_S1_Q16   = 18'd177051;  // s + 1.0
    localparam logic [11:0]        RECIP_20      = 12'd3277;    // 2^16 / 20, rounded up
    localparam logic [19:0]        RECIP_45      = 20'd745655;  // 2^25 / 45, rounded up

    // divider geometry
    localparam int DIVD_W = 41;  // dividend bits
    localparam int DIVS_W = 20;  // divisor bits
    localparam int QUO_W  = 18;  // quotient bits

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ,
        OP_CUBE,
        OP_NUM,
        OP_DIV,
        OP_EASE,
        OP_MUL,
        OP_ANG,
        OP_SPAN,
        OP_RECIP,
        OP_EMIT
    } op_t;

    // datapath status seen by the controller
    typedef struct packed {
        logic div_done;
        logic last_step;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/set_div.sv =====
// ----------------------------------------------------------------------------
// set_div
// Radix-2 restoring divider, one quotient bit per cycle.
// The quotient must fit in QUO_W bits.
// ----------------------------------------------------------------------------
module set_div
    import set_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic [QUO_W-1:0]  quotient,
    output logic              done
);

    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVS_W-1:0] dvs_reg, dvs_next;
    logic [QUO_W-1:0]  low_reg, low_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;

    // one shift-and-subtract step
    always_comb
    begin
        trial     = {rem_reg, low_reg[QUO_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        low_next  = low_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = dividend[DIVS_W+QUO_W-1:QUO_W];
            low_next  = dividend[QUO_W-1:0];
            dvs_next  = divisor;
            cnt_next  = 5'(QUO_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[DIVS_W])
            begin
                rem_next = diff[DIVS_W-1:0];
                low_next = {low_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVS_W-1:0];
                low_next = {low_reg[QUO_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        low_reg <= low_next;
    end

    assign quotient = low_reg;
    assign done     = !busy_reg;

endmodule

// ===== rtl/set_dpath.sv =====
// ----------------------------------------------------------------------------
// set_dpath
// Datapath: step count, easing value, angle blend, saturation and duty.
// Each operation from the controller loads one rank of registers.
// ----------------------------------------------------------------------------
module set_dpath
    import set_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  op_t                op,
    output status_t            status,
    // command item
    input  logic [31:0]        s_tdata,
    input  logic [0:0]         s_tuser,
    // configuration writes
    input  logic               cfg_valid,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    // result item
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [63:0]        m_tdata,
    output logic               m_tlast
);

    localparam int SW = $clog2(MAX_STEPS + 1);
    localparam logic [SW-1:0] MAX_N = SW'(MAX_STEPS);

    // configuration and stored position
    logic [CFG_W-1:0]   offset_reg, span_reg;
    logic [ANGLE_W-1:0] pos_p_reg, pos_t_reg;

    // command
    logic [GOAL_W-1:0]  goal_p_reg, goal_t_reg;
    logic               back_reg;
    logic [ANGLE_W-1:0] start_p_reg, start_t_reg;
    logic [SW-1:0]      n_reg, i_reg;

    // easing pipeline
    logic [13:0]        sq_i_reg, sq_d_reg, n2_reg;
    logic [20:0]        cube_i_reg, cube_d_reg, n3_reg;
    logic signed [25:0] blin_reg;
    logic               first_reg;
    logic [DIVD_W-1:0]  dvd_reg;
    logic [DIVS_W-1:0]  dvs_reg;
    logic               neg_reg;
    logic signed [19:0] ease_reg;

    // per-axis pipeline
    logic signed [38:0] prod_p_reg, prod_t_reg;
    logic [ANGLE_W-1:0] ang_p_reg, ang_t_reg;
    logic [28:0]        ad_p_reg, ad_t_reg;
    logic [DUTY_W-1:0]  rq_p_reg, rq_t_reg;

    // output register
    logic               ovalid_reg;
    logic [63:0]        odata_reg;
    logic               olast_reg;

    // divider
    logic               div_start;
    logic [QUO_W-1:0]   quo;
    logic               div_done;

    // combinational helpers
    logic [22:0]        dur_mul;
    logic [6:0]         dur_q;
    logic [SW-1:0]      n_new;
    logic [6:0]         i7, n7, d7;
    logic signed [41:0] num_a;
    logic signed [41:0] num_x;
    logic signed [19:0] qs;
    logic signed [17:0] diff_p, diff_t;
    logic signed [23:0] v_p, v_t;
    logic [ANGLE_W-1:0] sat_p, sat_t;
    logic [38:0]        rm_p, rm_t;
    logic               out_free;

    // saturate a blended angle to 0..180 degrees
    function automatic logic [ANGLE_W-1:0] sat_angle(input logic signed [23:0] v);
        logic [ANGLE_W-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > $signed({8'd0, ANGLE_MAX_Q8}))
            r = ANGLE_MAX_Q8;
        else
            r = v[ANGLE_W-1:0];
        return r;
    endfunction

    // step count: floor(duration / 20), clamped to 1..MAX_STEPS
    always_comb
    begin
        dur_mul = s_tdata[2*GOAL_W +: DUR_W] * RECIP_20;
        dur_q   = dur_mul[22:16];
        if (dur_q == 7'd0)
            n_new = SW'(1);
        else if ({25'd0, dur_q} > MAX_STEPS)
            n_new = MAX_N;
        else
            n_new = SW'(dur_q);
    end

    assign i7 = 7'(i_reg);
    assign n7 = 7'(n_reg);
    assign d7 = n7 - i7;

    // easing numerator, doubled and offset for round-to-nearest
    always_comb
    begin
        if (back_reg)
            num_a = 42'($signed({1'b0, sq_d_reg}) * blin_reg);
        else if (first_reg)
            num_a = $signed({3'd0, cube_i_reg, 18'd0});
        else
            num_a = $signed({3'd0, cube_d_reg, 18'd0});
        num_x = (num_a <<< 1) + $signed({21'd0, n3_reg});
    end

    // signed quotient back from the unsigned divider
    assign qs = neg_reg ? ~$signed({2'b00, quo}) : $signed({2'b00, quo});

    assign diff_p = $signed({2'b00, goal_p_reg, 8'd0}) - $signed({2'b00, start_p_reg});
    assign diff_t = $signed({2'b00, goal_t_reg, 8'd0}) - $signed({2'b00, start_t_reg});

    // blend and round: start + floor((E*diff + 32768) / 65536)
    assign v_p = $signed({8'd0, start_p_reg}) + 24'((prod_p_reg + 39'sd32768) >>> 16);
    assign v_t = $signed({8'd0, start_t_reg}) + 24'((prod_t_reg + 39'sd32768) >>> 16);
    assign sat_p = sat_angle(v_p);
    assign sat_t = sat_angle(v_t);

    // floor(x / 45) by reciprocal, x = (angle * span) / 1024
    assign rm_p = ad_p_reg[28:10] * RECIP_45;
    assign rm_t = ad_t_reg[28:10] * RECIP_45;

    assign out_free  = !ovalid_reg || m_tready;
    assign div_start = (op == OP_DIV);

    set_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_reg),
        .divisor  (dvs_reg),
        .quotient (quo),
        .done     (div_done)
    );

    // control state: config, positions, step counter, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_RESET;
            span_reg   <= SPAN_RESET;
            pos_p_reg  <= RESET_POS_Q8;
            pos_t_reg  <= RESET_POS_Q8;
            ovalid_reg <= 1'b0;
            i_reg      <= '0;
            n_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_DUTY_OFFSET: offset_reg <= cfg_data;
                    REG_DUTY_SPAN:   span_reg   <= cfg_data;
                    default:         ;
                endcase
            end
            if (m_tready)
                ovalid_reg <= 1'b0;
            case (op)
                OP_LOAD:
                begin
                    n_reg <= n_new;
                    i_reg <= SW'(1);
                end
                OP_EMIT:
                begin
                    ovalid_reg <= 1'b1;
                    i_reg      <= i_reg + SW'(1);
                    if (i_reg == n_reg)
                    begin
                        pos_p_reg <= ang_p_reg;
                        pos_t_reg <= ang_t_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                goal_p_reg  <= s_tdata[GOAL_W-1:0];
                goal_t_reg  <= s_tdata[GOAL_W +: GOAL_W];
                back_reg    <= s_tuser[0];
                start_p_reg <= pos_p_reg;
                start_t_reg <= pos_t_reg;
            end
            OP_SQ:
            begin
                sq_i_reg  <= i7 * i7;
                sq_d_reg  <= d7 * d7;
                n2_reg    <= n7 * n7;
                first_reg <= ({i7, 1'b0} < {1'b0, n7});
            end
            OP_CUBE:
            begin
                cube_i_reg <= sq_i_reg * i7;
                cube_d_reg <= sq_d_reg * d7;
                n3_reg     <= n2_reg * n7;
                blin_reg   <= $signed({1'b0, 25'(BACK_S_Q16 * n7)})
                            - $signed({1'b0, 25'(BACK_S1_Q16 * d7)});
            end
            OP_NUM:
            begin
                neg_reg <= num_x[41];
                dvd_reg <= num_x[41] ? DIVD_W'(~num_x) : DIVD_W'(num_x);
                dvs_reg <= {n3_reg[DIVS_W-2:0], 1'b0};
            end
            OP_EASE:
            begin
                if (back_reg)
                    ease_reg <= 20'sd65536 + qs;
                else if (first_reg)
                    ease_reg <= qs;
                else
                    ease_reg <= 20'sd65536 - qs;
            end
            OP_MUL:
            begin
                prod_p_reg <= 39'(ease_reg * diff_p);
                prod_t_reg <= 39'(ease_reg * diff_t);
            end
            OP_ANG:
            begin
                ang_p_reg <= sat_p;
                ang_t_reg <= sat_t;
            end
            OP_SPAN:
            begin
                ad_p_reg <= ang_p_reg * span_reg;
                ad_t_reg <= ang_t_reg * span_reg;
            end
            OP_RECIP:
            begin
                rq_p_reg <= rm_p[38:25];
                rq_t_reg <= rm_t[38:25];
            end
            OP_EMIT:
            begin
                odata_reg <= {4'd0,
                              DUTY_W'({1'b0, offset_reg} + rq_t_reg),
                              DUTY_W'({1'b0, offset_reg} + rq_p_reg),
                              ang_t_reg, ang_p_reg};
                olast_reg <= (i_reg == n_reg);
            end
            default: ;
        endcase
    end

    assign status.div_done  = div_done;
    assign status.last_step = (i_reg == n_reg);
    assign status.out_free  = out_free;

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tlast  = olast_reg;

endmodule

// ===== rtl/set_ctrl.sv =====
// ----------------------------------------------------------------------------
// set_ctrl
// Controller: sequences the per-step operations of the datapath.
// ----------------------------------------------------------------------------
module set_ctrl
    import set_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output op_t     op
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_CUBE,
        ST_NUM,
        ST_DIVGO,
        ST_DIVW,
        ST_EASE,
        ST_MUL,
        ST_ANG,
        ST_SPAN,
        ST_RECIP,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    // next state and operation for this cycle
    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op         = OP_LOAD;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                op         = OP_SQ;
                state_next = ST_CUBE;
            end
            ST_CUBE:
            begin
                op         = OP_CUBE;
                state_next = ST_NUM;
            end
            ST_NUM:
            begin
                op         = OP_NUM;
                state_next = ST_DIVGO;
            end
            ST_DIVGO:
            begin
                op         = OP_DIV;
                state_next = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (status.div_done)
                    state_next = ST_EASE;
            end
            ST_EASE:
            begin
                op         = OP_EASE;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                op         = OP_MUL;
                state_next = ST_ANG;
            end
            ST_ANG:
            begin
                op         = OP_ANG;
                state_next = ST_SPAN;
            end
            ST_SPAN:
            begin
                op         = OP_SPAN;
                state_next = ST_RECIP;
            end
            ST_RECIP:
            begin
                op         = OP_RECIP;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    op         = OP_EMIT;
                    state_next = status.last_step ? ST_IDLE : ST_SQ;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

// ===== rtl/servo_easing_trajectory.sv =====
// ----------------------------------------------------------------------------
// servo_easing_trajectory
// Eased two-axis servo move generator.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one move command item: goal pan and tilt in whole
//   degrees and a duration; s_tuser selects back-ease-out (1) or cubic
//   ease-in-out (0). The move is cut into duration/20 steps, 1 to MAX_STEPS.
//   The m_ channel gives one item per step: Q8.8 angles and servo duties;
//   m_tlast marks the final step, whose angles become the next start point.
//   The cfg_ channel writes duty_offset (index 0) and duty_span (index 1)
//   between moves; it is always ready.
// Sequence:
//   Each step runs square, cube, numerator, the radix-2 divider that forms
//   the easing value, ease, multiply, angle, span, reciprocal and emit, in
//   that order; the next command is taken once the last step has been
//   loaded into the output register.
// Reset and stall:
//   Reset restores both positions to 90 degrees and the duty registers to
//   205 and 410. When m_tready is low, the finished step waits in the output
//   register and the next step holds until it is taken.
// ----------------------------------------------------------------------------
module servo_easing_trajectory
    import set_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    // command: [7:0] goal_pan, [15:8] goal_tilt, [26:16] move_time
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,
    // [0] overshoot
    input  logic [0:0]       s_tuser,
    // result: [15:0] pan_angle, [31:16] tilt_angle, [45:32] pan_pwm,
    //         [59:46] tilt_pwm
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [63:0]      m_tdata,
    output logic             m_tlast,
    // configuration writes
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    op_t     op;
    status_t status;

    set_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .op       (op)
    );

    set_dpath #(
        .MAX_STEPS (MAX_STEPS)
    ) u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    assign cfg_ready = 1'b1;

endmodule
